/* sv/eauv_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the encoder angle unwrap and velocity block
// no dependencies
package eauv_pkg;

  localparam int ANGLE_W  = 12;
  localparam int TIME_W   = 63;
  localparam int POS_W    = 64;
  localparam int VEL_W    = 48;
  localparam int ALPHA_W  = 17;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int FUNC_W   = 2;

  localparam int MUL_A_W   = 49;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  localparam int DIV_N_W   = 39;
  localparam int DIV_D_W   = TIME_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  localparam int SMAG_W    = DIV_N_W + MUL_B_W - 16;
  localparam int BLEND_W   = 67;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_SET    = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE = 2'd2;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 17'd6554;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE       = 17'd65536;
  localparam logic [CFG_W-1:0]   DEADBAND_RESET  = 32'd0;
  localparam logic [CFG_W-1:0]   INV_SCALE_RESET = 32'd65536;

  localparam logic signed [13:0] TURN      = 14'sd4096;
  localparam logic signed [13:0] HALF_TURN = 14'sd2048;
  localparam logic [27:0]        SPEED_K   = 28'd256000000;

  localparam logic [VEL_W-1:0]  VEL_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [VEL_W-1:0]  VEL_MIN  = 48'h8000_0000_0000;
  localparam logic [SMAG_W-1:0] NEG_LIM  = 55'h0_8000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_POS, ST_NUM, ST_DIV, ST_SCL, ST_DIFF, ST_BLEND, ST_ROUND, ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* sv/eauv_item_if.sv */
`timescale 1ns / 1ps
// input word channel: command, angle, timestamp and load value
// depends on eauv_pkg
interface eauv_item_if import eauv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [ANGLE_W-1:0]       angle_sample;
  logic [TIME_W-1:0]        timestamp_us;
  logic signed [POS_W-1:0]  set_value;

  modport source (output valid, func, angle_sample, timestamp_us, set_value, input ready);
  modport sink   (input valid, func, angle_sample, timestamp_us, set_value, output ready);
endinterface

/* sv/eauv_result_if.sv */
`timescale 1ns / 1ps
// result word channel: position and filtered velocity
// depends on eauv_pkg
interface eauv_result_if import eauv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  position;
  logic signed [VEL_W-1:0]  velocity;

  modport source (output valid, position, velocity, input ready);
  modport sink   (input valid, position, velocity, output ready);
endinterface

/* sv/eauv_cfg_if.sv */
`timescale 1ns / 1ps
// register write channel: index and data
// depends on eauv_pkg
interface eauv_cfg_if import eauv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/eauv_mul.sv */
`timescale 1ns / 1ps
// bit-serial shift-add unsigned multiplier, one multiplier bit per cycle
// depends on eauv_pkg
module eauv_mul import eauv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output unit_stat_t         stat,
  output logic [MUL_P_W-1:0] prod
);

  logic [MUL_A_W-1:0]   a_r;
  logic [MUL_A_W-1:0]   hi;
  logic [MUL_B_W-1:0]   lo;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [MUL_A_W:0]     sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      hi  <= '0;
      lo  <= b;
      cnt <= '0;
    end else if (busy) begin
      hi  <= sum[MUL_A_W:1];
      lo  <= {sum[0], lo[MUL_B_W-1:1]};
      cnt <= cnt + 1'b1;
    end
  end

  assign stat = '{busy: busy, done: done};
  assign prod = {hi, lo};

endmodule

/* sv/eauv_div.sv */
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
// depends on eauv_pkg
module eauv_div import eauv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0] den,
  output unit_stat_t         stat,
  output logic [DIV_N_W-1:0] quo
);

  logic [DIV_D_W-1:0]   den_r;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_N_W-1:0]   q;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;
  logic                 ge;

  assign trial = {rem, q[DIV_N_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= '0;
      q     <= num;
      cnt   <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      q   <= {q[DIV_N_W-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  assign stat = '{busy: busy, done: done};
  assign quo  = q;

endmodule

/* sv/encoder_angle_unwrap_velocity.sv */
`timescale 1ns / 1ps
// Multi-turn unwrapper for a 12-bit absolute angle with a smoothed velocity estimate.
// A sample update runs load, then a shared bit-serial multiplier in four passes (step
// times inv_scale, step times 256e6, speed times inv_scale, the alpha blend), with a
// bit-serial divider for the speed after the second pass and blend setup before the
// last, then rounding, done and idle. When time has not advanced only the first pass
// runs. Set-position, start-tracking and unused command words go from load to done.
// One word is worked on at a time; the next is taken while the previous result still
// waits in the output register, and a finished word waits in place until that
// register is free.
// depends on eauv_pkg, eauv_item_if, eauv_result_if, eauv_cfg_if, eauv_mul, eauv_div
module encoder_angle_unwrap_velocity import eauv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  eauv_item_if.sink    item,
  eauv_result_if.source result,
  eauv_cfg_if.sink     cfg
);

  state_t state, state_next;

  logic [ALPHA_W-1:0] alpha_r;
  logic [CFG_W-1:0]   deadband_r;
  logic [CFG_W-1:0]   inv_scale_r;

  logic [FUNC_W-1:0]        func_r;
  logic [ANGLE_W-1:0]       ang_r;
  logic [TIME_W-1:0]        ts_r;
  logic signed [POS_W-1:0]  setv_r;

  logic [ANGLE_W-1:0]       last_angle;
  logic [TIME_W-1:0]        last_time;
  logic [POS_W-1:0]         position_acc;
  logic signed [VEL_W-1:0]  velocity_acc;

  logic                     dneg;
  logic [ANGLE_W-1:0]       dmag;
  logic [TIME_W-1:0]        dt;
  logic                     tadv;
  logic signed [VEL_W-1:0]  s_val;
  logic                     diff_neg;
  logic signed [BLEND_W-1:0] blend_acc;

  logic                     res_valid;
  logic signed [POS_W-1:0]  res_pos;
  logic signed [VEL_W-1:0]  res_vel;

  logic signed [13:0]       d_raw, d_wrap;
  logic [13:0]              d_abs;
  logic [ANGLE_W-1:0]       dmag_c;
  logic                     tadv_c;
  logic [DIV_N_W-1:0]       rmag_eff;
  logic [ALPHA_W-1:0]       alpha_eff;
  logic [SMAG_W-1:0]        smag;
  logic [VEL_W-1:0]         s_c;
  logic signed [VEL_W:0]    diff_c;
  logic [VEL_W:0]           diff_mag;
  logic [POS_W-1:0]         step;
  logic signed [BLEND_W-1:0] term;
  logic signed [BLEND_W-1:0] round_sum;

  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  unit_stat_t         mul_stat;
  logic [MUL_P_W-1:0] mul_prod;
  logic               div_start;
  unit_stat_t         div_stat;
  logic [DIV_N_W-1:0] div_quo;
  logic               out_free;
  logic               item_rdy;

  eauv_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  eauv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mul_prod[DIV_N_W-1:0]),
    .den   (dt),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // shortest signed step
  always_comb begin
    d_raw = $signed({2'b00, ang_r}) - $signed({2'b00, last_angle});
    if (d_raw > HALF_TURN) begin
      d_wrap = d_raw - TURN;
    end else if (d_raw < -HALF_TURN) begin
      d_wrap = d_raw + TURN;
    end else begin
      d_wrap = d_raw;
    end
    d_abs  = d_wrap[13] ? 14'(-d_wrap) : 14'(d_wrap);
    dmag_c = d_abs[ANGLE_W-1:0];
  end

  assign tadv_c    = ts_r > last_time;
  assign rmag_eff  = (div_quo < {7'b0, deadband_r}) ? '0 : div_quo;
  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign smag      = mul_prod[DIV_N_W+MUL_B_W-1:16];
  assign step      = {{(POS_W-ANGLE_W-MUL_B_W){1'b0}}, mul_prod[ANGLE_W+MUL_B_W-1:0]};
  assign out_free  = !res_valid || result.ready;

  // saturate the scaled speed
  always_comb begin
    if (!dneg) begin
      s_c = (|smag[SMAG_W-1:VEL_W-1]) ? VEL_MAX : smag[VEL_W-1:0];
    end else begin
      s_c = (smag > NEG_LIM) ? VEL_MIN : VEL_W'(-smag[VEL_W-1:0]);
    end
  end

  assign diff_c   = {s_val[VEL_W-1], s_val} - {velocity_acc[VEL_W-1], velocity_acc};
  assign diff_mag = diff_c[VEL_W] ? (VEL_W+1)'(-diff_c) : (VEL_W+1)'(diff_c);
  assign term     = diff_neg ? -$signed({1'b0, mul_prod[65:0]})
                             : $signed({1'b0, mul_prod[65:0]});
  assign round_sum = blend_acc + (blend_acc[BLEND_W-1] ? BLEND_W'(65535) : '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (item.valid) state_next = ST_LOAD;
      ST_LOAD:  state_next = (func_r == FUNC_SAMPLE) ? ST_POS : ST_DONE;
      ST_POS:   if (mul_stat.done) state_next = tadv ? ST_NUM : ST_DONE;
      ST_NUM:   if (mul_stat.done) state_next = ST_DIV;
      ST_DIV:   if (div_stat.done) state_next = ST_SCL;
      ST_SCL:   if (mul_stat.done) state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_BLEND;
      ST_BLEND: if (mul_stat.done) state_next = ST_ROUND;
      ST_ROUND: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // unit control and operands
  always_comb begin
    item_rdy  = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: item_rdy = 1'b1;
      ST_LOAD: begin
        mul_start = func_r == FUNC_SAMPLE;
        mul_a     = MUL_A_W'(dmag_c);
        mul_b     = inv_scale_r;
      end
      ST_POS: begin
        mul_start = mul_stat.done && tadv;
        mul_a     = MUL_A_W'(dmag);
        mul_b     = MUL_B_W'(SPEED_K);
      end
      ST_NUM: div_start = mul_stat.done;
      ST_DIV: begin
        mul_start = div_stat.done;
        mul_a     = MUL_A_W'(rmag_eff);
        mul_b     = inv_scale_r;
      end
      ST_DIFF: begin
        mul_start = 1'b1;
        mul_a     = diff_mag;
        mul_b     = MUL_B_W'(alpha_eff);
      end
      default: ;
    endcase
  end

  assign item.ready = item_rdy;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_r     <= ALPHA_RESET;
      deadband_r  <= DEADBAND_RESET;
      inv_scale_r <= INV_SCALE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ALPHA:     alpha_r     <= cfg.data[ALPHA_W-1:0];
        CFG_DEADBAND:  deadband_r  <= cfg.data;
        CFG_INV_SCALE: inv_scale_r <= cfg.data;
        default: ;
      endcase
    end
  end

  // input word latch
  always_ff @(posedge clk) begin
    if (item.valid && item_rdy) begin
      func_r <= item.func;
      ang_r  <= item.angle_sample;
      ts_r   <= item.timestamp_us;
      setv_r <= item.set_value;
    end
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_angle   <= '0;
      last_time    <= '0;
      position_acc <= '0;
      velocity_acc <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          unique case (func_r)
            FUNC_SAMPLE: begin
              last_angle <= ang_r;
              last_time  <= ts_r;
            end
            FUNC_SET: begin
              position_acc <= setv_r;
              last_angle   <= ang_r;
            end
            FUNC_START: begin
              position_acc <= '0;
              velocity_acc <= '0;
              last_angle   <= ang_r;
              last_time    <= ts_r;
            end
            default: ;
          endcase
        end
        ST_POS: begin
          if (mul_stat.done) begin
            position_acc <= dneg ? position_acc - step : position_acc + step;
          end
        end
        ST_ROUND: velocity_acc <= round_sum[VEL_W+15:16];
        default: ;
      endcase
    end
  end

  // sample scratch
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      dneg <= d_wrap[13];
      dmag <= dmag_c;
      dt   <= ts_r - last_time;
      tadv <= tadv_c;
    end
    if (state == ST_SCL && mul_stat.done) begin
      s_val <= s_c;
    end
    if (state == ST_DIFF) begin
      diff_neg <= diff_c[VEL_W];
    end
    if (state == ST_BLEND && mul_stat.done) begin
      blend_acc <= term + {{3{velocity_acc[VEL_W-1]}}, velocity_acc, 16'b0};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      res_pos <= position_acc;
      res_vel <= velocity_acc;
    end
  end

  assign result.valid    = res_valid;
  assign result.position = res_pos;
  assign result.velocity = res_vel;

  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished outside its phase");

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == ST_POS || state == ST_NUM || state == ST_SCL ||
                       state == ST_BLEND))
    else $error("multiplier finished outside a multiply phase");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (res_valid && state == ST_IDLE))
    else $error("finished word not placed in output register");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for encoder_angle_unwrap_velocity: a queue-fed driver, a
// monitor with random stalls and a cycle-free tracker model of unwrap, position and velocity
// depends on eauv_pkg, eauv_item_if, eauv_result_if, eauv_cfg_if and the block itself
module tb_top import eauv_pkg::*; ();

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int N_PHASES = 7;
  localparam int PHASE_WORDS = 222;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [ANGLE_W-1:0]      angle;
    logic [TIME_W-1:0]       ts;
    logic signed [POS_W-1:0] setv;
  } enc_word_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [VEL_W-1:0] vel;
  } motion_t;

  typedef struct {
    logic [ALPHA_W-1:0] alpha;
    logic [CFG_W-1:0]   deadband;
    logic [CFG_W-1:0]   inv_scale;
    int                 send_idle;
    int                 recv_stall;
    bit                 hold;
  } phase_t;

  logic clk = 1'b0;
  logic rst;

  eauv_item_if   item_ch ();
  eauv_result_if res_ch ();
  eauv_cfg_if    cfg_ch ();

  encoder_angle_unwrap_velocity dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // tracker model state and register copies
  logic [ALPHA_W-1:0]      alpha_r;
  logic [CFG_W-1:0]        deadband_r;
  logic [CFG_W-1:0]        inv_scale_r;
  logic [ANGLE_W-1:0]      prev_angle;
  logic [TIME_W-1:0]       prev_time;
  logic [POS_W-1:0]        pos_model;
  logic signed [VEL_W-1:0] vel_model;

  enc_word_t in_words[$];
  motion_t   due_results[$];
  enc_word_t cur_word;
  motion_t   seen_due;

  int send_idle = 0;
  int recv_stall = 0;
  int hold_cnt;
  logic hold_req = 1'b0;
  int n_bad = 0;

  logic [ANGLE_W-1:0] gen_angle;
  logic [TIME_W-1:0]  gen_time;

  function automatic void track_word(input enc_word_t w);
    int d;
    logic [63:0] dmag;
    logic [63:0] stp;
    logic [63:0] dt;
    logic [63:0] rmag;
    logic [127:0] smag;
    logic [127:0] lim;
    logic signed [79:0] s_v;
    logic signed [79:0] a_v;
    logic signed [79:0] v_ext;
    logic signed [79:0] blend;
    motion_t m;
    case (w.func)
      FUNC_SAMPLE: begin
        d = int'(w.angle) - int'(prev_angle);
        if (d > int'(HALF_TURN)) d = d - int'(TURN);
        else if (d < -int'(HALF_TURN)) d = d + int'(TURN);
        dmag = (d < 0) ? 64'(-d) : 64'(d);
        stp = dmag * 64'(inv_scale_r);
        pos_model = (d < 0) ? pos_model - stp : pos_model + stp;
        if (w.ts > prev_time) begin
          dt = 64'(w.ts - prev_time);
          rmag = (dmag * 64'(SPEED_K)) / dt;
          if (rmag < 64'(deadband_r)) rmag = '0;
          smag = (128'(rmag) * 128'(inv_scale_r)) >> 16;
          lim = (d < 0) ? 128'(VEL_MIN) : 128'(VEL_MAX);
          if (smag > lim) smag = lim;
          s_v = $signed({1'b0, smag[78:0]});
          if (d < 0) s_v = -s_v;
          a_v = (alpha_r > ALPHA_ONE) ? $signed(80'(ALPHA_ONE)) : $signed(80'(alpha_r));
          v_ext = 80'(vel_model);
          blend = a_v * s_v + ($signed(80'(ALPHA_ONE)) - a_v) * v_ext;
          vel_model = 48'(blend / 80'sd65536);
        end
        prev_angle = w.angle;
        prev_time = w.ts;
      end
      FUNC_SET: begin
        pos_model = w.setv;
        prev_angle = w.angle;
      end
      FUNC_START: begin
        pos_model = '0;
        vel_model = '0;
        prev_angle = w.angle;
        prev_time = w.ts;
      end
      default: ;
    endcase
    m.pos = pos_model;
    m.vel = vel_model;
    due_results.push_back(m);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) track_word(cur_word);
      if (!item_ch.valid || item_ch.ready) begin
        if (in_words.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_word = in_words.pop_front();
          item_ch.func <= cur_word.func;
          item_ch.angle_sample <= cur_word.angle;
          item_ch.timestamp_us <= cur_word.ts;
          item_ch.set_value <= cur_word.setv;
          item_ch.valid <= 1'b1;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (hold_req && hold_cnt == 0) begin
      hold_cnt <= HOLD_CYCLES;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result word: position %0d velocity %0d",
                 res_ch.position, res_ch.velocity);
          n_bad++;
        end else begin
          seen_due = due_results.pop_front();
          if (res_ch.position !== seen_due.pos) begin
            $error("position mismatch: expected %0d, actual %0d",
                   $signed(seen_due.pos), res_ch.position);
            n_bad++;
          end
          if (res_ch.velocity !== seen_due.vel) begin
            $error("velocity mismatch: expected %0d, actual %0d",
                   $signed(seen_due.vel), res_ch.velocity);
            n_bad++;
          end
        end
      end
      res_ch.ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic queue_word(input logic [FUNC_W-1:0] f, input logic [ANGLE_W-1:0] a,
                            input logic [TIME_W-1:0] t, input logic signed [POS_W-1:0] v);
    enc_word_t w;
    w.func = f;
    w.angle = a;
    w.ts = t;
    w.setv = v;
    in_words.push_back(w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_ALPHA:     alpha_r = val[ALPHA_W-1:0];
      CFG_DEADBAND:  deadband_r = val;
      CFG_INV_SCALE: inv_scale_r = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    do @(negedge clk);
    while (in_words.size() != 0 || item_ch.valid || due_results.size() != 0);
  endtask

  task automatic queue_random(input int n);
    int r;
    int stp;
    logic [FUNC_W-1:0] f;
    logic signed [POS_W-1:0] v;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      f = (r < 88) ? FUNC_SAMPLE : (r < 93) ? FUNC_SET : (r < 97) ? FUNC_START : FUNC_UNUSED;
      r = $urandom_range(99);
      if (r < 70) stp = int'($urandom_range(64)) - 32;
      else if (r < 80) stp = int'($urandom_range(1000)) - 500;
      else if (r < 85) stp = 2048;
      else if (r < 90) stp = ($urandom_range(1) != 0) ? 2049 : -2049;
      else stp = int'($urandom_range(4095));
      gen_angle = gen_angle + 12'(stp);
      r = $urandom_range(99);
      if (r < 80) gen_time = gen_time + 63'($urandom_range(2000, 1));
      else if (r < 85) gen_time = gen_time + 63'($urandom);
      else if (r < 90) gen_time = gen_time;
      else if (r < 95) gen_time = gen_time - 63'($urandom_range(1000, 1));
      else gen_time = 63'({$urandom, $urandom});
      r = $urandom_range(99);
      if (r < 5) v = {1'b0, {63{1'b1}}};
      else if (r < 10) v = {1'b1, 63'b0};
      else v = {$urandom, $urandom};
      queue_word(f, gen_angle, gen_time, v);
    end
  endtask

  initial begin : stim
    phase_t plan [N_PHASES];
    item_ch.valid = 1'b0;
    item_ch.func = '0;
    item_ch.angle_sample = '0;
    item_ch.timestamp_us = '0;
    item_ch.set_value = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    alpha_r = ALPHA_RESET;
    deadband_r = DEADBAND_RESET;
    inv_scale_r = INV_SCALE_RESET;
    prev_angle = '0;
    prev_time = '0;
    pos_model = '0;
    vel_model = '0;
    gen_angle = '0;
    gen_time = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // unwrap edges, stalled and reversed time, wrap of position, commands
    queue_word(FUNC_START, 12'd0, 63'd0, 64'sd0);
    queue_word(FUNC_SAMPLE, 12'd2048, 63'd1000, 64'sd0);
    queue_word(FUNC_SAMPLE, 12'd0, 63'd2000, 64'sd0);
    queue_word(FUNC_SAMPLE, 12'd2049, 63'd2001, 64'sd0);
    queue_word(FUNC_SAMPLE, 12'd0, 63'd2002, 64'sd0);
    queue_word(FUNC_SAMPLE, 12'd4095, 63'd2003, 64'sd0);
    queue_word(FUNC_SAMPLE, 12'd0, 63'd2003, 64'sd0);
    queue_word(FUNC_SAMPLE, 12'd10, 63'd1500, 64'sd0);
    queue_word(FUNC_SAMPLE, 12'd2058, 63'd1501, 64'sd0);
    queue_word(FUNC_SET, 12'd4095, 63'd7, {1'b0, {63{1'b1}}});
    queue_word(FUNC_SAMPLE, 12'd0, 63'd2010, 64'sd0);
    queue_word(FUNC_SET, 12'd0, 63'd9, {1'b1, 63'b0});
    queue_word(FUNC_SAMPLE, 12'd4095, 63'd2020, 64'sd0);
    queue_word(FUNC_UNUSED, 12'd1234, {63{1'b1}}, -64'sd1);
    queue_word(FUNC_START, 12'd4095, {63{1'b1}}, 64'sd5);
    queue_word(FUNC_SAMPLE, 12'd100, 63'd0, 64'sd0);
    queue_word(FUNC_SAMPLE, 12'd200, {63{1'b1}}, 64'sd0);
    queue_word(FUNC_SET, 12'hAAA, 63'h2AAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    queue_word(FUNC_START, 12'h555, 63'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_word(FUNC_SAMPLE, 12'hD55, 63'h5555_5555_5555_5556, 64'sd0);
    queue_word(FUNC_SAMPLE, 12'h555, 63'h5555_5555_5555_5557, 64'sd0);
    drain();
    gen_angle = prev_angle;
    gen_time = prev_time;

    plan[0] = '{ALPHA_ONE, 32'd0, 32'd65536, 0, 0, 1'b1};
    plan[1] = '{17'd0, 32'd1_000_000, 32'd1, 80, 0, 1'b0};
    plan[2] = '{17'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 80, 1'b0};
    plan[3] = '{17'd32768, 32'd5000, 32'd0, 11, 11, 1'b0};
    plan[4] = '{ALPHA_RESET, 32'd0, 32'hFFFF_FFFF, 0, 0, 1'b1};
    plan[5] = '{17'($urandom_range(131071)), 32'($urandom_range(20_000_000)),
                32'($urandom_range(32'hFFFF_FFFF, 1)), 80, 0, 1'b0};
    plan[6] = '{17'd1, 32'd1, 32'($urandom_range(200_000, 1)), 0, 80, 1'b0};

    for (int k = 0; k < N_PHASES; k++) begin
      write_reg(CFG_ALPHA, 32'(plan[k].alpha));
      write_reg(CFG_DEADBAND, plan[k].deadband);
      write_reg(CFG_INV_SCALE, plan[k].inv_scale);
      @(negedge clk);
      send_idle = plan[k].send_idle;
      recv_stall = plan[k].recv_stall;
      queue_random(PHASE_WORDS);
      if (plan[k].hold) begin
        @(negedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        hold_req = 1'b0;
      end
      drain();
    end

    repeat (400) @(negedge clk);
    if (due_results.size() != 0) begin
      $error("%0d expected result words never arrived", due_results.size());
      n_bad++;
    end
    if (n_bad == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
